@@ hdl/key_value_table_defines.svh @@
// ----------------------------------------------------------------------------
// key_value_table defines
// Assertion macros used by the key/value table RTL.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_TABLE_DEFINES_SVH
`define KEY_VALUE_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define KVT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define KVT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/kvt_pkg.sv @@
// ----------------------------------------------------------------------------
// kvt_pkg
// Types and constants of the key/value table.
// ----------------------------------------------------------------------------
package kvt_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int KEY_BITS_DEF   = 32;
   localparam int VALUE_BITS_DEF = 32;

   localparam int FIELD_W     = 32;
   localparam int OP_W        = 3;
   localparam int INDEX_W     = 6;
   localparam int COUNT_OUT_W = 7;

   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP = 3'd0,
      OP_INSERT = 3'd1,
      OP_UPDATE = 3'd2,
      OP_UPSERT = 3'd3,
      OP_ERASE  = 3'd4,
      OP_INDEX  = 3'd5
   } kvt_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_APPLY,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_IDX_RD,
      ST_IDX_CAP,
      ST_DONE
   } kvt_state_type;

   typedef struct packed {
      logic key_we;
      logic val_we;
   } kvt_we_type;

endpackage

@@ hdl/kvt_store.sv @@
// ----------------------------------------------------------------------------
// kvt_store
// Key and value storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kvt_store import kvt_pkg::*; #(
   parameter  int DEPTH = CAPACITY_DEF,
   parameter  int KEY_W = KEY_BITS_DEF,
   parameter  int VAL_W = VALUE_BITS_DEF,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  kvt_we_type       wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [KEY_W-1:0] wr_key,
   input  logic [VAL_W-1:0] wr_val,
   input  logic [AW-1:0]    rd_addr,
   output logic [KEY_W-1:0] rd_key,
   output logic [VAL_W-1:0] rd_val
);

   logic [KEY_W-1:0] key_mem [DEPTH];
   logic [VAL_W-1:0] val_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en.key_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (wr_en.val_we) begin
         val_mem[wr_addr] <= wr_val;
      end
      rd_key <= key_mem[rd_addr];
      rd_val <= val_mem[rd_addr];
   end

endmodule

@@ hdl/key_value_table.sv @@
// ----------------------------------------------------------------------------
// key_value_table
// Packed key/value table with linear search, insert, update, upsert, erase with
// compaction, and read by index.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy stays high until
// its single result has been shown on the rsp_ ports for one cycle with
// rsp_valid, and the receiver must take it then. The search reads the entries
// from the store one at a time (read, then compare the registered data), and
// an erase then moves every entry behind the erased one up by one place, each
// with a read and then a write; read by index reads the entry only when the
// index is in range, and unused codes go straight to the result.
// The store comes out of reset with no live entries and needs no clearing.
// ----------------------------------------------------------------------------
`include "key_value_table_defines.svh"

module key_value_table import kvt_pkg::*; #(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [OP_W-1:0]        req_operation,
   input  logic [FIELD_W-1:0]     req_key,
   input  logic [FIELD_W-1:0]     req_value,
   input  logic [INDEX_W-1:0]     req_index,
   output logic                   rsp_valid,
   output logic                   rsp_ok,
   output logic [FIELD_W-1:0]     rsp_out_key,
   output logic [FIELD_W-1:0]     rsp_out_value,
   output logic [COUNT_OUT_W-1:0] rsp_live_count,
   output logic                   rsp_is_empty
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int KW = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
   localparam int VW = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
   localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

   kvt_state_type      state_ff, state_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [KW-1:0]      key_ff, key_in;
   logic [VW-1:0]      value_ff, value_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               hit_ff, hit_in;
   logic               ok_ff, ok_in;
   logic [KW-1:0]      rkey_ff, rkey_in;
   logic [VW-1:0]      rval_ff, rval_in;

   kvt_we_type    wr_en;
   logic [AW-1:0] wr_addr;
   logic [KW-1:0] wr_key;
   logic [VW-1:0] wr_val;
   logic [AW-1:0] rd_addr;
   logic [KW-1:0] rd_key;
   logic [VW-1:0] rd_val;

   logic          accept;
   logic          at_end;
   logic          key_match;
   logic          full;
   logic          idx_ok;
   logic          more_to_move;
   logic [CW-1:0] ptr_next;

   kvt_store #(
      .DEPTH (CAPACITY),
      .KEY_W (KW),
      .VAL_W (VW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_key  (wr_key),
      .wr_val  (wr_val),
      .rd_addr (rd_addr),
      .rd_key  (rd_key),
      .rd_val  (rd_val)
   );

   assign accept       = start && (state_ff == ST_IDLE);
   assign ptr_next     = ptr_ff + CW'(1);
   assign at_end       = (ptr_ff == count_ff);
   assign key_match    = (rd_key == key_ff);
   assign full         = (count_ff == CW'(CAPACITY));
   assign idx_ok       = (XW'(index_ff) < XW'(count_ff));
   assign more_to_move = (ptr_next < count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_operation == OP_INDEX) begin
                  state_in = ST_IDX_RD;
               end else if (req_operation > OP_INDEX) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ:     state_in = at_end ? ST_APPLY : ST_CMP;
         ST_CMP:      state_in = key_match ? ST_APPLY : ST_READ;
         ST_APPLY:    state_in = (op_ff == OP_ERASE && hit_ff) ? ST_SHIFT_RD : ST_DONE;
         ST_SHIFT_RD: state_in = more_to_move ? ST_SHIFT_WR : ST_DONE;
         ST_SHIFT_WR: state_in = ST_SHIFT_RD;
         ST_IDX_RD:   state_in = idx_ok ? ST_IDX_CAP : ST_DONE;
         ST_IDX_CAP:  state_in = ST_DONE;
         ST_DONE:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and store control
   always_comb begin
      op_in    = op_ff;
      key_in   = key_ff;
      value_in = value_ff;
      index_in = index_ff;
      ptr_in   = ptr_ff;
      count_in = count_ff;
      hit_in   = hit_ff;
      ok_in    = ok_ff;
      rkey_in  = rkey_ff;
      rval_in  = rval_ff;
      wr_en    = '0;
      wr_addr  = AW'(ptr_ff);
      wr_key   = key_ff;
      wr_val   = value_ff;
      rd_addr  = AW'(ptr_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_operation;
               key_in   = KW'(req_key);
               value_in = VW'(req_value);
               index_in = req_index;
               ptr_in   = '0;
               hit_in   = 1'b0;
               ok_in    = 1'b0;
               rkey_in  = KW'(req_key);
               rval_in  = '0;
            end
         end
         ST_READ: begin
         end
         ST_CMP: begin
            if (key_match) begin
               hit_in = 1'b1;
               if (op_ff == OP_LOOKUP) begin
                  rval_in = rd_val;
               end
            end else begin
               ptr_in = ptr_next;
            end
         end
         ST_APPLY: begin
            case (op_ff)
               OP_LOOKUP: ok_in = hit_ff;
               OP_INSERT: begin
                  if (!hit_ff && !full) begin
                     wr_en    = '{key_we: 1'b1, val_we: 1'b1};
                     wr_addr  = AW'(count_ff);
                     count_in = count_ff + CW'(1);
                     ok_in    = 1'b1;
                  end
               end
               OP_UPDATE: begin
                  if (hit_ff) begin
                     wr_en.val_we = 1'b1;
                     ok_in        = 1'b1;
                  end
               end
               OP_UPSERT: begin
                  if (hit_ff) begin
                     wr_en.val_we = 1'b1;
                     ok_in        = 1'b1;
                  end else if (!full) begin
                     wr_en    = '{key_we: 1'b1, val_we: 1'b1};
                     wr_addr  = AW'(count_ff);
                     count_in = count_ff + CW'(1);
                     ok_in    = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SHIFT_RD: begin
            if (more_to_move) begin
               rd_addr = AW'(ptr_next);
            end else begin
               count_in = count_ff - CW'(1);
               ok_in    = 1'b1;
            end
         end
         ST_SHIFT_WR: begin
            wr_en  = '{key_we: 1'b1, val_we: 1'b1};
            wr_key = rd_key;
            wr_val = rd_val;
            ptr_in = ptr_next;
         end
         ST_IDX_RD: begin
            rd_addr = AW'(index_ff);
         end
         ST_IDX_CAP: begin
            ok_in   = 1'b1;
            rkey_in = rd_key;
            rval_in = rd_val;
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      key_ff   <= key_in;
      value_ff <= value_in;
      index_ff <= index_in;
      ptr_ff   <= ptr_in;
      hit_ff   <= hit_in;
      ok_ff    <= ok_in;
      rkey_ff  <= rkey_in;
      rval_ff  <= rval_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_DONE);
   assign rsp_ok         = ok_ff;
   assign rsp_out_key    = FIELD_W'(rkey_ff);
   assign rsp_out_value  = FIELD_W'(rval_ff);
   assign rsp_live_count = COUNT_OUT_W'(count_ff);
   assign rsp_is_empty   = (count_ff == '0);

   `KVT_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(CAPACITY), "live count above capacity")
   `KVT_ASSERT_NEXT(a_accept_busy, accept, busy, "no busy after accepted beat")
   `KVT_ASSERT_NEXT(a_rsp_single, rsp_valid, !busy && !rsp_valid, "result beat not single")
   `KVT_ASSERT_NEXT(a_count_step, !busy, $stable(count_ff), "count moved while idle")

endmodule

@@ verif/tb_key_value_table.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_value_table
// Sends lookup, insert, update, upsert, erase, index-read and unused-code beats
// to the key/value table in random-length bursts. A shadow copy predicts each
// response that a directed row does not give itself; all are checked field by
// field in order. A short directed table covers empty, duplicate, missing-key,
// out-of-range and unused-code cases. The random part cycles through grow,
// balanced and shrink mixes so the table fills up, runs full and drains.
// ----------------------------------------------------------------------------
module tb_key_value_table import kvt_pkg::*;;

   localparam int CAPACITY     = CAPACITY_DEF;
   localparam int RANDOM_BEATS = 1400;
   localparam int PAUSE_AT     = 700;
   localparam int DRAIN_CYCLES = 4 * CAPACITY + 16;
   localparam int LIMIT_CYCLES = 2_000_000;
   localparam int DIR_ROWS     = 24;
   localparam int POOL_SIZE    = 96;
   localparam logic [FIELD_W-1:0] POOL_BASE = 32'h1000_0000;
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [FIELD_W-1:0] key;
      logic [FIELD_W-1:0] value;
      logic [INDEX_W-1:0] index;
   } kv_cmd_type;

   typedef struct packed {
      logic                   ok;
      logic [FIELD_W-1:0]     key;
      logic [FIELD_W-1:0]     value;
      logic [COUNT_OUT_W-1:0] count;
      logic                   empty;
   } kv_rsp_type;

   typedef struct packed {
      kv_cmd_type cmd;
      logic       typed;
      kv_rsp_type want;
   } dir_row_type;

   typedef enum int { MIX_GROW, MIX_BALANCED, MIX_SHRINK } mix_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [OP_W-1:0]        req_operation = '0;
   logic [FIELD_W-1:0]     req_key = '0;
   logic [FIELD_W-1:0]     req_value = '0;
   logic [INDEX_W-1:0]     req_index = '0;
   logic                   rsp_valid;
   logic                   rsp_ok;
   logic [FIELD_W-1:0]     rsp_out_key;
   logic [FIELD_W-1:0]     rsp_out_value;
   logic [COUNT_OUT_W-1:0] rsp_live_count;
   logic                   rsp_is_empty;

   logic [FIELD_W-1:0] shadow_key [CAPACITY];
   logic [FIELD_W-1:0] shadow_value [CAPACITY];
   int                 shadow_count = 0;
   kv_rsp_type         pending_rsp [$];
   int                 mismatch_count = 0;
   int                 cycle_count = 0;
   int                 burst_left = 0;
   dir_row_type        dir_rows [DIR_ROWS];

   key_value_table DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_key        (req_key),
      .req_value      (req_value),
      .req_index      (req_index),
      .rsp_valid      (rsp_valid),
      .rsp_ok         (rsp_ok),
      .rsp_out_key    (rsp_out_key),
      .rsp_out_value  (rsp_out_value),
      .rsp_live_count (rsp_live_count),
      .rsp_is_empty   (rsp_is_empty)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // shadow table: applies one beat, returns the response it should produce
   function automatic kv_rsp_type shadow_apply(input kv_cmd_type c);
      kv_rsp_type r;
      int         pos;
      int         i;
      logic       hit;
      r.ok    = 1'b0;
      r.key   = c.key;
      r.value = '0;
      pos = shadow_count;
      for (i = shadow_count - 1; i >= 0; i--)
         if (shadow_key[i] == c.key) pos = i;
      hit = (pos < shadow_count);
      case (c.op)
         OP_LOOKUP: if (hit) begin
            r.ok    = 1'b1;
            r.value = shadow_value[pos];
         end
         OP_INSERT: if (!hit && shadow_count < CAPACITY) begin
            shadow_key[shadow_count]   = c.key;
            shadow_value[shadow_count] = c.value;
            shadow_count++;
            r.ok = 1'b1;
         end
         OP_UPDATE: if (hit) begin
            shadow_value[pos] = c.value;
            r.ok = 1'b1;
         end
         OP_UPSERT: if (hit) begin
            shadow_value[pos] = c.value;
            r.ok = 1'b1;
         end else if (shadow_count < CAPACITY) begin
            shadow_key[shadow_count]   = c.key;
            shadow_value[shadow_count] = c.value;
            shadow_count++;
            r.ok = 1'b1;
         end
         OP_ERASE: if (hit) begin
            for (i = pos; i < shadow_count - 1; i++) begin
               shadow_key[i]   = shadow_key[i + 1];
               shadow_value[i] = shadow_value[i + 1];
            end
            shadow_count--;
            r.ok = 1'b1;
         end
         OP_INDEX: if (int'(c.index) < shadow_count) begin
            r.ok    = 1'b1;
            r.key   = shadow_key[c.index];
            r.value = shadow_value[c.index];
         end
         default: ;
      endcase
      r.count = shadow_count[COUNT_OUT_W-1:0];
      r.empty = (shadow_count == 0);
      return r;
   endfunction

   function automatic dir_row_type dir_row(input logic [OP_W-1:0] op,
                                           input logic [FIELD_W-1:0] key,
                                           input logic [FIELD_W-1:0] value,
                                           input logic [INDEX_W-1:0] index,
                                           input logic typed,
                                           input logic ok,
                                           input logic [FIELD_W-1:0] out_key,
                                           input logic [FIELD_W-1:0] out_value,
                                           input logic [COUNT_OUT_W-1:0] count);
      dir_row_type r;
      r.cmd.op     = op;
      r.cmd.key    = key;
      r.cmd.value  = value;
      r.cmd.index  = index;
      r.typed      = typed;
      r.want.ok    = ok;
      r.want.key   = out_key;
      r.want.value = out_value;
      r.want.count = count;
      r.want.empty = (count == 0);
      return r;
   endfunction

   function automatic kv_cmd_type random_cmd(input mix_type mix);
      kv_cmd_type c;
      int         roll;
      int         pick;
      int         live_share;
      int         t_ins;
      int         t_ups;
      int         t_look;
      int         t_upd;
      int         t_era;
      case (mix)
         MIX_GROW:     begin t_ins = 40; t_ups = 75; t_look = 83; t_upd = 88; t_era = 94; end
         MIX_SHRINK:   begin t_ins = 10; t_ups = 16; t_look = 28; t_upd = 36; t_era = 80; end
         default:      begin t_ins = 18; t_ups = 33; t_look = 50; t_upd = 64; t_era = 82; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 3)           c.op = (roll == 0) ? OP_SPARE_HI : OP_SPARE_LO;
      else if (roll < t_ins)  c.op = OP_INSERT;
      else if (roll < t_ups)  c.op = OP_UPSERT;
      else if (roll < t_look) c.op = OP_LOOKUP;
      else if (roll < t_upd)  c.op = OP_UPDATE;
      else if (roll < t_era)  c.op = OP_ERASE;
      else                    c.op = OP_INDEX;
      live_share = (mix == MIX_SHRINK) ? 70 : 35;
      pick = $urandom_range(0, 99);
      if (shadow_count > 0 && pick < live_share)
         c.key = shadow_key[$urandom_range(0, shadow_count - 1)];
      else if (pick < live_share + 40)
         c.key = POOL_BASE + $urandom_range(0, POOL_SIZE - 1);
      else
         c.key = $urandom;
      c.value = $urandom;
      if ($urandom_range(0, 99) < 60)
         c.index = INDEX_W'($urandom_range(0, (shadow_count > 63) ? 63 : shadow_count));
      else
         c.index = INDEX_W'($urandom_range(0, 63));
      return c;
   endfunction

   task automatic send_beat(input kv_cmd_type c, input logic typed, input kv_rsp_type want);
      kv_rsp_type pred;
      int         gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 10);
      end
      burst_left--;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= c.op;
      req_key       <= c.key;
      req_value     <= c.value;
      req_index     <= c.index;
      do @(posedge clock); while (busy !== 1'b0);
      pred = shadow_apply(c);
      pending_rsp.push_back(typed ? want : pred);
   endtask

   initial begin : sender
      int         n;
      int         segment_left;
      mix_type    mix;
      kv_cmd_type cmd;
      dir_rows[0]  = dir_row(OP_LOOKUP, 32'h0, 32'h0, 6'd0, 1'b1,
                             1'b0, 32'h0, 32'h0, 7'd0);
      dir_rows[1]  = dir_row(OP_INDEX, 32'h5, 32'h0, 6'd0, 1'b1,
                             1'b0, 32'h5, 32'h0, 7'd0);
      dir_rows[2]  = dir_row(OP_ERASE, 32'hFFFF_FFFF, 32'h0, 6'd0, 1'b1,
                             1'b0, 32'hFFFF_FFFF, 32'h0, 7'd0);
      dir_rows[3]  = dir_row(OP_UPDATE, 32'h1, 32'hFFFF_FFFF, 6'd0, 1'b1,
                             1'b0, 32'h1, 32'h0, 7'd0);
      dir_rows[4]  = dir_row(OP_INSERT, 32'h0, 32'hFFFF_FFFF, 6'd0, 1'b1,
                             1'b1, 32'h0, 32'h0, 7'd1);
      dir_rows[5]  = dir_row(OP_INSERT, 32'hFFFF_FFFF, 32'h0, 6'd63, 1'b1,
                             1'b1, 32'hFFFF_FFFF, 32'h0, 7'd2);
      // duplicate key
      dir_rows[6]  = dir_row(OP_INSERT, 32'h0, 32'h1, 6'd0, 1'b1,
                             1'b0, 32'h0, 32'h0, 7'd2);
      dir_rows[7]  = dir_row(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 6'd0, 1'b1,
                             1'b1, 32'hFFFF_FFFF, 32'h0, 7'd2);
      dir_rows[8]  = dir_row(OP_LOOKUP, 32'h0, 32'h0, 6'd0, 1'b1,
                             1'b1, 32'h0, 32'hFFFF_FFFF, 7'd2);
      dir_rows[9]  = dir_row(OP_UPDATE, 32'h0, 32'h1234_5678, 6'd0, 1'b0,
                             1'b0, '0, '0, '0);
      dir_rows[10] = dir_row(OP_UPSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 6'd0, 1'b0,
                             1'b0, '0, '0, '0);
      dir_rows[11] = dir_row(OP_UPSERT, 32'h7, 32'h3, 6'd0, 1'b0,
                             1'b0, '0, '0, '0);
      dir_rows[12] = dir_row(OP_INDEX, 32'hAAAA_AAAA, 32'h0, 6'd2, 1'b0,
                             1'b0, '0, '0, '0);
      // index at and past the live count
      dir_rows[13] = dir_row(OP_INDEX, 32'h5555_5555, 32'h0, 6'd3, 1'b1,
                             1'b0, 32'h5555_5555, 32'h0, 7'd3);
      dir_rows[14] = dir_row(OP_INDEX, 32'h0, 32'h0, 6'd63, 1'b1,
                             1'b0, 32'h0, 32'h0, 7'd3);
      dir_rows[15] = dir_row(OP_SPARE_LO, 32'h9, 32'h9, 6'd0, 1'b1,
                             1'b0, 32'h9, 32'h0, 7'd3);
      dir_rows[16] = dir_row(OP_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 1'b1,
                             1'b0, 32'hFFFF_FFFF, 32'h0, 7'd3);
      // erase front entry, then last entry, then a missing one, then the only one left
      dir_rows[17] = dir_row(OP_ERASE, 32'h0, 32'h0, 6'd0, 1'b0,
                             1'b0, '0, '0, '0);
      dir_rows[18] = dir_row(OP_INDEX, 32'h0, 32'h0, 6'd0, 1'b0,
                             1'b0, '0, '0, '0);
      dir_rows[19] = dir_row(OP_LOOKUP, 32'h0, 32'h0, 6'd0, 1'b0,
                             1'b0, '0, '0, '0);
      dir_rows[20] = dir_row(OP_ERASE, 32'h7, 32'h0, 6'd0, 1'b0,
                             1'b0, '0, '0, '0);
      dir_rows[21] = dir_row(OP_ERASE, 32'h7, 32'h0, 6'd0, 1'b0,
                             1'b0, '0, '0, '0);
      dir_rows[22] = dir_row(OP_ERASE, 32'hFFFF_FFFF, 32'h0, 6'd0, 1'b0,
                             1'b0, '0, '0, '0);
      dir_rows[23] = dir_row(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 6'd0, 1'b0,
                             1'b0, '0, '0, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIR_ROWS; n++)
         send_beat(dir_rows[n].cmd, dir_rows[n].typed, dir_rows[n].want);

      mix = MIX_GROW;
      segment_left = $urandom_range(120, 250);
      for (n = 0; n < RANDOM_BEATS; n++) begin
         if (n == PAUSE_AT) begin
            start <= 1'b0;
            do @(posedge clock); while (pending_rsp.size() != 0);
         end
         if (segment_left == 0) begin
            mix = mix_type'((int'(mix) + 1) % 3);
            segment_left = $urandom_range(120, 250);
         end
         segment_left--;
         cmd = random_cmd(mix);
         send_beat(cmd, 1'b0, '0);
      end

      start <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock) begin : rsp_check
      kv_rsp_type got;
      kv_rsp_type want;
      got = {rsp_ok, rsp_out_key, rsp_out_value, rsp_live_count, rsp_is_empty};
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected beat at cycle %0d: ok %b key %h value %h count %0d",
                        cycle_count, got.ok, got.key, got.value, got.count);
         end else begin
            want = pending_rsp.pop_front();
            if (got.ok !== want.ok || got.key !== want.key || got.value !== want.value ||
                got.count !== want.count || got.empty !== want.empty) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $write("mismatch at cycle %0d (exp/got): ok %b/%b key %h/%h ",
                         cycle_count, want.ok, got.ok, want.key, got.key);
                  $display("value %h/%h count %0d/%0d empty %b/%b",
                           want.value, got.value, want.count, got.count,
                           want.empty, got.empty);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule
